FILE: rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: shared constants for the line/rectangle clipper
// Register indexes, lane classification codes and output widths.
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam int OUT_W   = 24;  // Q16.8 output coordinate
	localparam int CFG_IW  = 2;   // config register index width
	localparam int LN_W    = 3;   // lane class code width

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_IW-1:0] REG_Y_MIN = 2'd1;
	localparam logic [CFG_IW-1:0] REG_X_MAX = 2'd2;
	localparam logic [CFG_IW-1:0] REG_Y_MAX = 2'd3;

	// lane (border) classification of q/p
	localparam logic [LN_W-1:0] LN_SKIP = 3'd0;  // p == 0, no t update
	localparam logic [LN_W-1:0] LN_ZERO = 3'd1;  // q == 0, t = 0
	localparam logic [LN_W-1:0] LN_NEG  = 3'd2;  // ratio below 0
	localparam logic [LN_W-1:0] LN_OVR  = 3'd3;  // ratio above 1
	localparam logic [LN_W-1:0] LN_ONE  = 3'd4;  // ratio exactly 1
	localparam logic [LN_W-1:0] LN_DIV  = 3'd5;  // fraction from divider

endpackage

FILE: rtl/lrc_ifs.sv
// ----------------------------------------------------------------------------
// lrc_ifs: segment and clip result channels
// Valid/ready channels carrying one segment or one clipped result.
// ----------------------------------------------------------------------------
interface lrc_seg_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrc_clip_if;
	logic                            valid;
	logic                            ready;
	logic                            visible;
	logic signed [lrc_pkg::OUT_W-1:0] clip_start_x;
	logic signed [lrc_pkg::OUT_W-1:0] clip_start_y;
	logic signed [lrc_pkg::OUT_W-1:0] clip_end_x;
	logic signed [lrc_pkg::OUT_W-1:0] clip_end_y;

	modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface

FILE: rtl/line_rect_clipper.sv
// ----------------------------------------------------------------------------
// line_rect_clipper: Liang-Barsky segment clipper against a config window
// Term setup, bit-per-stage dividers for the four borders, entry/exit
// combine, endpoint multiply and final add.
// ----------------------------------------------------------------------------
// Stages: setup register, one per quotient bit, combine, multiply, output.
// Throughput: one segment per clock; the whole pipeline holds when the
// result is not taken, and accepts a new segment in the same cycle a result leaves.
// Reset: arst_n clears the stage valid bits and the window registers to 0.
module line_rect_clipper #(
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lrc_pkg::CFG_IW-1:0]     cfg_idx,
	input  logic [COORD_BITS-1:0]          cfg_data,
	lrc_seg_if.sink                        seg,
	lrc_clip_if.source                     clip
);
	import lrc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int T  = T_FRAC_BITS;
	localparam int DW = C + 1;              // p, q, deltas, magnitudes
	localparam int TW = T + 2;              // signed t: -1 .. 2^T+1
	localparam int PD = TW + DW;            // product width
	localparam int PW = (PD + 1 > OUT_W + 2) ? PD + 1 : OUT_W + 2;
	localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< T;
	localparam logic signed [TW-1:0] T_OVR = (TW'(1) <<< T) + TW'(1);
	localparam logic signed [TW-1:0] T_NEG = -TW'(1);

	// window registers
	logic signed [C-1:0] xmn_q, ymn_q, xmx_q, ymx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmn_q <= '0;
			ymn_q <= '0;
			xmx_q <= '0;
			ymx_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_X_MIN: xmn_q <= cfg_data;
				REG_Y_MIN: ymn_q <= cfg_data;
				REG_X_MAX: xmx_q <= cfg_data;
				REG_Y_MAX: ymx_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_v_s4;
	assign adv       = !out_v_s4 || clip.ready;
	assign seg.ready = adv;

	// ---------------- term setup ----------------
	logic signed [DW-1:0] xa_e, ya_e, xb_e, yb_e;
	logic signed [DW-1:0] pd [4];
	logic signed [DW-1:0] qd [4];
	logic [DW-1:0]        qa [4];
	logic [DW-1:0]        pa [4];
	logic [LN_W-1:0]      cls [4];
	logic [3:0]           prej, pneg;

	assign xa_e = DW'(seg.start_x);
	assign ya_e = DW'(seg.start_y);
	assign xb_e = DW'(seg.end_x);
	assign yb_e = DW'(seg.end_y);

	always_comb begin
		pd[0] = xa_e - xb_e;  qd[0] = xa_e - DW'(xmn_q);
		pd[1] = xb_e - xa_e;  qd[1] = DW'(xmx_q) - xa_e;
		pd[2] = ya_e - yb_e;  qd[2] = ya_e - DW'(ymn_q);
		pd[3] = yb_e - ya_e;  qd[3] = DW'(ymx_q) - ya_e;
		for (int k = 0; k < 4; k++) begin
			qa[k]   = qd[k][DW-1] ? DW'(-qd[k]) : DW'(qd[k]);
			pa[k]   = pd[k][DW-1] ? DW'(-pd[k]) : DW'(pd[k]);
			pneg[k] = pd[k][DW-1];
			prej[k] = (pd[k] == '0) && qd[k][DW-1];
			if (pd[k] == '0)
				cls[k] = LN_SKIP;
			else if (qd[k] == '0)
				cls[k] = LN_ZERO;
			else if (qd[k][DW-1] != pd[k][DW-1])
				cls[k] = LN_NEG;
			else if (qa[k] > pa[k])
				cls[k] = LN_OVR;
			else if (qa[k] == pa[k])
				cls[k] = LN_ONE;
			else
				cls[k] = LN_DIV;
		end
	end

	// ---------------- divider chain ----------------
	// index 0 is the setup register, index j holds j quotient bits
	logic [T:0]                 dv_v_sd;
	logic signed [C-1:0]        dv_xa_sd  [T+1];
	logic signed [C-1:0]        dv_ya_sd  [T+1];
	logic signed [DW-1:0]       dv_dx_sd  [T+1];
	logic signed [DW-1:0]       dv_dy_sd  [T+1];
	logic [T:0]                 dv_rej_sd;
	logic [3:0]                 dv_neg_sd [T+1];
	logic [LN_W-1:0]            dv_cls_sd [T+1][4];
	logic [DW-1:0]              dv_rem_sd [T+1][4];
	logic [DW-1:0]              dv_den_sd [T+1][4];
	logic [T-1:0]               dv_quo_sd [T+1][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_sd[0] <= 1'b0;
		else if (adv)
			dv_v_sd[0] <= seg.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_xa_sd[0]  <= seg.start_x;
			dv_ya_sd[0]  <= seg.start_y;
			dv_dx_sd[0]  <= xb_e - xa_e;
			dv_dy_sd[0]  <= yb_e - ya_e;
			dv_rej_sd[0] <= |prej;
			dv_neg_sd[0] <= pneg;
			for (int k = 0; k < 4; k++) begin
				dv_cls_sd[0][k] <= cls[k];
				dv_rem_sd[0][k] <= qa[k];
				dv_den_sd[0][k] <= pa[k];
				dv_quo_sd[0][k] <= '0;
			end
		end
	end

	for (genvar j = 1; j <= T; j++) begin : g_div
		logic [DW:0]   r2  [4];
		logic [DW:0]   dif [4];
		logic [3:0]    qb;

		always_comb begin
			for (int k = 0; k < 4; k++) begin
				r2[k]  = {dv_rem_sd[j-1][k], 1'b0};
				dif[k] = r2[k] - {1'b0, dv_den_sd[j-1][k]};
				qb[k]  = !dif[k][DW];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_sd[j] <= 1'b0;
			else if (adv)
				dv_v_sd[j] <= dv_v_sd[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_xa_sd[j]  <= dv_xa_sd[j-1];
				dv_ya_sd[j]  <= dv_ya_sd[j-1];
				dv_dx_sd[j]  <= dv_dx_sd[j-1];
				dv_dy_sd[j]  <= dv_dy_sd[j-1];
				dv_rej_sd[j] <= dv_rej_sd[j-1];
				dv_neg_sd[j] <= dv_neg_sd[j-1];
				for (int k = 0; k < 4; k++) begin
					dv_cls_sd[j][k] <= dv_cls_sd[j-1][k];
					dv_den_sd[j][k] <= dv_den_sd[j-1][k];
					dv_rem_sd[j][k] <= qb[k] ? DW'(dif[k]) : DW'(r2[k]);
					dv_quo_sd[j][k] <= {dv_quo_sd[j-1][k][T-2:0], qb[k]};
				end
			end
		end
	end

	// ---------------- entry/exit combine ----------------
	logic signed [TW-1:0] tl [4];
	logic signed [TW-1:0] ts_c, te_c;

	always_comb begin
		ts_c = '0;
		te_c = T_ONE;
		for (int k = 0; k < 4; k++) begin
			case (dv_cls_sd[T][k])
				LN_ZERO: tl[k] = '0;
				LN_NEG:  tl[k] = T_NEG;
				LN_OVR:  tl[k] = T_OVR;
				LN_ONE:  tl[k] = T_ONE;
				default: tl[k] = TW'(dv_quo_sd[T][k]);
			endcase
			if (dv_cls_sd[T][k] != LN_SKIP) begin
				if (dv_neg_sd[T][k]) begin
					if (tl[k] > ts_c)
						ts_c = tl[k];
				end else if (tl[k] < te_c) begin
					te_c = tl[k];
				end
			end
		end
	end

	logic                 v_s2, ok_s2;
	logic signed [TW-1:0] ts_s2, te_s2;
	logic signed [C-1:0]  xa_s2, ya_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= dv_v_sd[T];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2 <= !dv_rej_sd[T] && (ts_c <= te_c);
			ts_s2 <= ts_c;
			te_s2 <= te_c;
			xa_s2 <= dv_xa_sd[T];
			ya_s2 <= dv_ya_sd[T];
			dx_s2 <= dv_dx_sd[T];
			dy_s2 <= dv_dy_sd[T];
		end
	end

	// ---------------- endpoint multiply ----------------
	logic                 v_s3, ok_s3;
	logic signed [C-1:0]  xa_s3, ya_s3;
	logic signed [PD-1:0] psx_s3, psy_s3, pex_s3, pey_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3  <= ok_s2;
			xa_s3  <= xa_s2;
			ya_s3  <= ya_s2;
			psx_s3 <= PD'(ts_s2 * dx_s2);
			psy_s3 <= PD'(ts_s2 * dy_s2);
			pex_s3 <= PD'(te_s2 * dx_s2);
			pey_s3 <= PD'(te_s2 * dy_s2);
		end
	end

	// ---------------- final add ----------------
	// floor(t*d / 2^(T-8)) via arithmetic shift, plus start point in Q.8
	logic signed [PW-1:0] base_x, base_y, rsx, rsy, rex, rey;

	assign base_x = PW'(xa_s3) <<< 8;
	assign base_y = PW'(ya_s3) <<< 8;
	assign rsx = base_x + (PW'(psx_s3) >>> (T - 8));
	assign rsy = base_y + (PW'(psy_s3) >>> (T - 8));
	assign rex = base_x + (PW'(pex_s3) >>> (T - 8));
	assign rey = base_y + (PW'(pey_s3) >>> (T - 8));

	logic                    vis_s4;
	logic signed [OUT_W-1:0] sx_s4, sy_s4, ex_s4, ey_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_s4 <= 1'b0;
		else if (adv)
			out_v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s4 <= ok_s3;
			sx_s4  <= ok_s3 ? rsx[OUT_W-1:0] : '0;
			sy_s4  <= ok_s3 ? rsy[OUT_W-1:0] : '0;
			ex_s4  <= ok_s3 ? rex[OUT_W-1:0] : '0;
			ey_s4  <= ok_s3 ? rey[OUT_W-1:0] : '0;
		end
	end

	assign clip.valid        = out_v_s4;
	assign clip.visible      = vis_s4;
	assign clip.clip_start_x = sx_s4;
	assign clip.clip_start_y = sy_s4;
	assign clip.clip_end_x   = ex_s4;
	assign clip.clip_end_y   = ey_s4;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for line_rect_clipper
// Segments are driven in random bursts against several clipping windows;
// each clipped result is checked against a bit-exact Liang-Barsky predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lrc_pkg::*;

	localparam int CB = 16;
	localparam int TF = 16;
	localparam int WDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [CB-1:0] sx, sy, ex, ey;
	} seg_t;

	typedef struct packed {
		logic                    vis;
		logic signed [OUT_W-1:0] csx, csy, cex, cey;
	} clip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_idx = '0;
	logic [CB-1:0] cfg_data = '0;

	lrc_seg_if #(.COORD_BITS(CB)) seg();
	lrc_clip_if clip();

	line_rect_clipper #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .seg(seg.sink), .clip(clip.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// window copy used by the predictor
	logic signed [CB-1:0] w_xmn = '0, w_ymn = '0, w_xmx = '0, w_ymx = '0;

	seg_t  seg_pending[$];
	clip_t clip_expected[$];
	int    mismatches = 0;
	int    wdog = 0;

	// t of q/p: -1 below zero, one+1 above one, else truncated
	function automatic longint border_t(longint q, longint p);
		longint one, a, b, r, t;
		one = longint'(1) << TF;
		if (q == 0) return 0;
		if ((q < 0) != (p < 0)) return -1;
		a = q < 0 ? -q : q;
		b = p < 0 ? -p : p;
		if (a > b) return one + 1;
		if (a == b) return one;
		r = a;
		t = 0;
		for (int i = 0; i < TF; i++) begin
			r = r <<< 1;
			t = t <<< 1;
			if (r >= b) begin
				r = r - b;
				t = t | 1;
			end
		end
		return t;
	endfunction

	// floor of Q16.8 point a + t*(b-a)
	function automatic logic [OUT_W-1:0] point_at(longint a, longint b, longint t);
		longint prod;
		prod = a * (longint'(1) << TF) + t * (b - a);
		return OUT_W'(prod >>> (TF - 8));
	endfunction

	function automatic clip_t clip_segment(seg_t s);
		longint xa, ya, xb, yb, ts, te, t;
		longint p[4], q[4];
		bit ok;
		clip_t r;
		xa = s.sx; ya = s.sy; xb = s.ex; yb = s.ey;
		p[0] = xa - xb; q[0] = xa - longint'(w_xmn);
		p[1] = xb - xa; q[1] = longint'(w_xmx) - xa;
		p[2] = ya - yb; q[2] = ya - longint'(w_ymn);
		p[3] = yb - ya; q[3] = longint'(w_ymx) - ya;
		ts = 0;
		te = longint'(1) << TF;
		ok = 1;
		for (int i = 0; i < 4 && ok; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0) ok = 0;
			end else begin
				t = border_t(q[i], p[i]);
				if (p[i] < 0) begin
					if (t > ts) ts = t;
				end else if (t < te) te = t;
				if (ts > te) ok = 0;
			end
		end
		r = '0;
		if (ok) begin
			r.vis = 1'b1;
			r.csx = point_at(xa, xb, ts);
			r.csy = point_at(ya, yb, ts);
			r.cex = point_at(xa, xb, te);
			r.cey = point_at(ya, yb, te);
		end
		return r;
	endfunction

	// driver: bursts with random gaps; the driven segment stays at the queue head
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.valid <= 1'b0;
			seg.start_x <= '0; seg.start_y <= '0; seg.end_x <= '0; seg.end_y <= '0;
		end else begin
			if (seg.valid && seg.ready) begin
				clip_expected = {clip_expected, clip_segment(seg_pending.pop_front())};
			end
			if (!(seg.valid && !seg.ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					seg.valid <= 1'b0;
				end else if (seg_pending.size() > 0) begin
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 5);
					end else burst_left <= burst_left - 1;
					seg.valid <= 1'b1;
					{seg.start_x, seg.start_y, seg.end_x, seg.end_y} <= seg_pending[0];
				end else seg.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern and result check
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: clip.ready <= 1'b1;
				1: clip.ready <= $urandom_range(0, 1);
				2: clip.ready <= ($urandom_range(0, 7) == 0);
				default: clip.ready <= ($urandom_range(0, 7) != 0);
			endcase
			if (clip.valid && clip.ready) begin
				if (clip_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected clip transaction");
				end else begin
					clip_t e, a;
					e = clip_expected.pop_front();
					a = {clip.visible, clip.clip_start_x, clip.clip_start_y,
						clip.clip_end_x, clip.clip_end_y};
					if (a !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp vis=%0b %0d %0d %0d %0d act vis=%0b %0d %0d %0d %0d",
								e.vis, e.csx, e.csy, e.cex, e.cey,
								a.vis, a.csx, a.csy, a.cex, a.cey);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((seg.valid && seg.ready) || (clip.valid && clip.ready)) wdog <= 0;
			else if (seg_pending.size() > 0 || clip_expected.size() > 0) wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic signed [CB-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_X_MIN: w_xmn = v;
			REG_Y_MIN: w_ymn = v;
			REG_X_MAX: w_xmx = v;
			default:   w_ymx = v;
		endcase
	endtask

	task automatic set_window(input int xmn, input int ymn, input int xmx, input int ymx);
		write_reg(REG_X_MIN, CB'(xmn));
		write_reg(REG_Y_MIN, CB'(ymn));
		write_reg(REG_X_MAX, CB'(xmx));
		write_reg(REG_Y_MAX, CB'(ymx));
	endtask

	task automatic drain();
		while (seg_pending.size() > 0 || clip_expected.size() > 0 || seg.valid)
			@(posedge clk);
		repeat (TF + 10) @(posedge clk);
	endtask

	function automatic logic [CB-1:0] rnd_coord(int span);
		case ($urandom_range(0, 5))
			0: return CB'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return CB'($urandom_range(0, 2 * span) - span);
		endcase
	endfunction

	task automatic add_seg(input int sx, input int sy, input int ex, input int ey);
		seg_t s;
		s.sx = CB'(sx); s.sy = CB'(sy); s.ex = CB'(ex); s.ey = CB'(ey);
		seg_pending = {seg_pending, s};
	endtask

	initial begin
		seg_t s;
		int span;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// reset window: zero-size at origin
		add_seg(0, 0, 0, 0);
		add_seg(1, 0, 1, 0);
		add_seg(-5, 0, 5, 0);
		drain();
		set_window(-100, -50, 100, 50);
		add_seg(0, 0, 0, 0);          // point inside
		add_seg(100, 50, 100, 50);    // point on corner
		add_seg(101, 0, 101, 0);      // point outside
		add_seg(-200, 0, 200, 0);     // crosses both x borders
		add_seg(200, 0, -200, 0);
		add_seg(0, -300, 0, 300);
		add_seg(-300, 60, 300, 60);   // parallel, outside
		add_seg(-300, -300, 300, 300);
		add_seg(-300, 300, 300, -300);
		add_seg(150, 0, 0, 100);      // misses corner
		add_seg(-32768, -32768, 32767, 32767);
		add_seg(32767, -32768, -32768, 32767);
		add_seg(7, 3, 301, 49);       // near-equal entry/exit
		add_seg(99, 49, 101, 51);
		drain();
		set_window(10, 10, -10, -10); // inverted
		add_seg(0, 0, 0, 0);
		add_seg(-20, -20, 20, 20);
		drain();
		set_window(-32768, -32768, 32767, 32767);
		add_seg(-32768, 32767, 32767, -32768);
		add_seg(32767, 32767, 32767, 32767);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			int a, b, c, d;
			span = (ph % 2) ? 32768 : 400;
			a = $signed(rnd_coord(span)); b = $signed(rnd_coord(span));
			c = $signed(rnd_coord(span)); d = $signed(rnd_coord(span));
			if (ph < 6) begin
				set_window(a < c ? a : c, b < d ? b : d, a < c ? c : a, b < d ? d : b);
			end else set_window(a, b, c, d);
			for (int i = 0; i < 100; i++) begin
				s.sx = rnd_coord(span); s.sy = rnd_coord(span);
				s.ex = ($urandom_range(0, 9) == 0) ? s.sx : rnd_coord(span);
				s.ey = ($urandom_range(0, 9) == 0) ? s.sy : rnd_coord(span);
				seg_pending = {seg_pending, s};
			end
			drain();
		end
		if (mismatches == 0 && clip_expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
